[hw/rtl/tssm_pkg.sv]
// Types and constants shared by the two-stack shared-memory block.
// No dependencies; every other file in hw/rtl imports this package.
package tssm_pkg;

    localparam int unsigned DATA_W = 32;

    // Action codes carried in the command transfer
    typedef enum logic [2:0] {
        ACT_PUSH_A = 3'd0,
        ACT_PUSH_B = 3'd1,
        ACT_POP_A  = 3'd2,
        ACT_POP_B  = 3'd3,
        ACT_PEEK_A = 3'd4,
        ACT_PEEK_B = 3'd5
    } t_action;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Data returned by a pop on an empty stack
    localparam logic signed [DATA_W-1:0] POP_EMPTY_DATA = -32'sd1;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic                     empty_a;
        logic                     empty_b;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FORM
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming command
        logic exec;     // memory access and pointer update
        logic form;     // load the result register
    } t_dp_ctl;

endpackage

[hw/rtl/two_stacks_shared_memory.sv]
// Two stacks in one memory of DEPTH words: A grows up from entry 0, B down from DEPTH-1.
// A command transferred in idle goes through the execute state, then the form-result
// state, and its result strobe is registered from the latter. No new command is taken
// until both steps around the single memory port are done (busy covers both).
// Reset (synchronous, active low) empties both stacks and idles the sequencer; memory
// contents are not cleared. Results cannot be held off by the receiver.
module two_stacks_shared_memory #(
    parameter int unsigned DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tssm_pkg::t_cmd_in i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output tssm_pkg::t_result o_result
);
    import tssm_pkg::*;

    // Command bundle from the sequencer to the datapath
    t_dp_ctl ctl;

    // Sequencer: a command transfers when i_start is high in the idle state,
    // then an execute state (memory write or read, count update) and a
    // state that loads the result register. o_done pulses for one cycle.
    tssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    // Datapath: the shared memory, both counts, overflow/underflow decode
    // and the registered result shown while o_done is high.
    tssm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cmd    (i_cmd),
        .o_result (o_result)
    );

endmodule

[hw/rtl/tssm_ctrl.sv]
// Sequencer for the two-stack block: idle, execute, form result.
// Depends on tssm_pkg.
module tssm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output tssm_pkg::t_dp_ctl o_ctl
);
    import tssm_pkg::*;

    t_state r_state, n_state;
    logic   r_done,  n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_FORM;
            end
            S_FORM: begin
                o_ctl.form = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

[hw/rtl/tssm_dp.sv]
// Datapath: shared word memory, the two stack counts and the result register.
// Depends on tssm_pkg; sequenced by tssm_ctrl.
module tssm_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tssm_pkg::t_dp_ctl i_ctl,
    input  tssm_pkg::t_cmd_in i_cmd,
    output tssm_pkg::t_result o_result
);
    import tssm_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [2:0]               r_action;
    logic signed [DATA_W-1:0] r_value;
    logic [CW-1:0]            r_cnt_a, n_cnt_a;
    logic [CW-1:0]            r_cnt_b, n_cnt_b;
    logic signed [DATA_W-1:0] r_rd_data;
    logic [1:0]               r_status, n_status;
    logic                     r_use_mem, n_use_mem;
    logic                     r_neg_one, n_neg_one;
    t_result                  r_res;

    logic [CW:0]   sum_cnt;
    logic          full;
    logic [CW:0]   a_next, a_top, b_next, b_top;
    logic [AW-1:0] addr;
    logic          wr_en;

    assign sum_cnt = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign full    = (sum_cnt >= DEPTH_W);
    assign a_next  = {1'b0, r_cnt_a};
    assign a_top   = {1'b0, r_cnt_a} - (CW + 1)'(1);
    assign b_top   = DEPTH_W - {1'b0, r_cnt_b};
    assign b_next  = b_top - (CW + 1)'(1);

    // Decode of the latched action
    always_comb begin
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_status  = ST_OK;
        n_use_mem = 1'b0;
        n_neg_one = 1'b0;
        wr_en     = 1'b0;
        addr      = a_next[AW-1:0];
        unique case (r_action)
            ACT_PUSH_A: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    addr    = a_next[AW-1:0];
                    n_cnt_a = r_cnt_a + CW'(1);
                end
            end
            ACT_PUSH_B: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    addr    = b_next[AW-1:0];
                    n_cnt_b = r_cnt_b + CW'(1);
                end
            end
            ACT_POP_A, ACT_PEEK_A: begin
                addr = a_top[AW-1:0];
                if (r_cnt_a == '0) begin
                    n_status  = ST_UNDERFLOW;
                    n_neg_one = (r_action == ACT_POP_A);
                end else begin
                    n_use_mem = 1'b1;
                    if (r_action == ACT_POP_A) begin
                        n_cnt_a = r_cnt_a - CW'(1);
                    end
                end
            end
            ACT_POP_B, ACT_PEEK_B: begin
                addr = b_top[AW-1:0];
                if (r_cnt_b == '0) begin
                    n_status  = ST_UNDERFLOW;
                    n_neg_one = (r_action == ACT_POP_B);
                end else begin
                    n_use_mem = 1'b1;
                    if (r_action == ACT_POP_B) begin
                        n_cnt_b = r_cnt_b - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Shared memory: one registered read per execute cycle, plus one write when wr_en is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            if (wr_en) begin
                mem[addr] <= r_value;
            end
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (i_ctl.exec) begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_action <= i_cmd.action;
            r_value  <= i_cmd.value;
        end
        if (i_ctl.exec) begin
            r_status  <= n_status;
            r_use_mem <= n_use_mem;
            r_neg_one <= n_neg_one;
        end
        if (i_ctl.form) begin
            r_res.data    <= r_use_mem ? r_rd_data :
                             (r_neg_one ? POP_EMPTY_DATA : '0);
            r_res.status  <= r_status;
            r_res.empty_a <= (r_cnt_a == '0);
            r_res.empty_b <= (r_cnt_b == '0);
        end
    end

    assign o_result = r_res;

endmodule

[hw/rtl/tssm_checker.sv]
// Port-level checks for two_stacks_shared_memory, attached by bind.
// Depends on tssm_pkg.
module tssm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input tssm_pkg::t_result o_result
);
    import tssm_pkg::*;

    // An accepted command yields its result strobe after the execute and form-result states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("result strobe missing after accepted transfer");

    // The sequencer is back in idle when the strobe shows
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("busy while result strobe is high");

    // Status codes beyond underflow never appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_OVERFLOW ||
                    o_result.status == ST_UNDERFLOW))
        else $error("illegal status code");

    // Overflow needs a full memory, so both stacks can never be empty then
    a_ovf_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_OVERFLOW) |-> !(o_result.empty_a && o_result.empty_b))
        else $error("overflow reported with both stacks empty");

endmodule

bind two_stacks_shared_memory tssm_checker u_tssm_checker (.*);
